### src/pcac_pkg.sv
// ----------------------------------------------------------------------------
// pcac_pkg: shared types for the pneumatic cylinder actuator control unit
// Command codes, configuration register indexes, phase encoding and the
// request, result, configuration and state structures.
// ----------------------------------------------------------------------------
package pcac_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TMR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_POLL_EXT  = 3'd0,
    CMD_POLL_RET  = 3'd1,
    CMD_FORCE_ON  = 3'd2,
    CMD_FORCE_OFF = 3'd3,
    CMD_RESET     = 3'd4,
    CMD_TICK      = 3'd5,
    CMD_ABORT_EXT = 3'd6,
    CMD_ABORT_RET = 3'd7
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_EN     = 3'd0,
    CFG_SENS_EN    = 3'd1,
    CFG_POLARITY   = 3'd2,
    CFG_EXT_TMO    = 3'd3,
    CFG_RET_TMO    = 3'd4,
    CFG_EXT_SETTLE = 3'd5,
    CFG_RET_SETTLE = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_RETRY  = 4'b0010,
    PH_WAIT   = 4'b0100,
    PH_SETTLE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       extend_sensor_raw;
    logic       retract_sensor_raw;
    logic       system_running;
    logic       handler_paused;
  } in_data_t;

  typedef struct packed {
    logic             motion_done;
    logic             valve_drive;
    logic             position_status;
    logic             cylinder_extended;
    logic             motions_idle;
    logic             alarm_raise;
    logic             alarm_clear;
    logic             alarm_side;
    logic [CNT_W-1:0] timeout_total;
    logic [CNT_W-1:0] transition_total;
  } out_data_t;

  typedef struct packed {
    logic             actuator_enable;
    logic [1:0]       sensor_enables;
    logic [2:0]       polarity_bits;
    logic [TMR_W-1:0] extend_timeout;
    logic [TMR_W-1:0] retract_timeout;
    logic [TMR_W-1:0] extend_settle;
    logic [TMR_W-1:0] retract_settle;
  } cfg_t;

  typedef struct packed {
    phase_t           ext_phase;
    phase_t           ret_phase;
    logic             ext_fail;
    logic             ret_fail;
    logic [TMR_W-1:0] ext_wait;
    logic [TMR_W-1:0] ret_wait;
    logic [TMR_W-1:0] ext_settle_tmr;
    logic [TMR_W-1:0] ret_settle_tmr;
    logic             status_flag;
    logic             extended_flag;
    logic             last_dir;
    logic             first_cmd;
    logic             valve_level;
    logic [CNT_W-1:0] tmo_cnt;
    logic [CNT_W-1:0] trans_cnt;
  } state_t;

endpackage

### src/pcac_core.sv
// ----------------------------------------------------------------------------
// pcac_core: command decode and next-state logic
// Works out the next cylinder state and the result fields for one request
// from the current state, the configuration and the request payload.
// ----------------------------------------------------------------------------
module pcac_core import pcac_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    st,
  input  in_data_t  req,
  output state_t    st_nxt,
  output out_data_t rsp
);

  typedef struct packed {
    phase_t           phase;
    logic             fails;
    logic [TMR_W-1:0] wait_tmr;
    logic [TMR_W-1:0] settle_tmr;
    logic             status_wr;
    logic             status_val;
    logic             raise;
    logic             success;
  } poll_t;

  localparam logic [TMR_W-1:0] TMR_ONE = {{(TMR_W-1){1'b0}}, 1'b1};

  function automatic logic [TMR_W-1:0] dec_tmr(input logic [TMR_W-1:0] t);
    dec_tmr = (t != '0) ? (t - TMR_ONE) : t;
  endfunction

  // one poll of one direction, is_ret selects the retract flavor
  function automatic poll_t poll_side(
    input logic             is_ret,
    input phase_t           phase,
    input logic             fails,
    input logic [TMR_W-1:0] wait_tmr,
    input logic [TMR_W-1:0] settle_tmr,
    input logic [TMR_W-1:0] tmo,
    input logic [TMR_W-1:0] settle,
    input logic             fitted,
    input logic             sensed,
    input logic             running,
    input logic             paused
  );
    poll_t r;
    logic  confirm;
    logic  stop;
    logic  fail;
    r.phase      = phase;
    r.fails      = fails;
    r.wait_tmr   = wait_tmr;
    r.settle_tmr = settle_tmr;
    r.status_wr  = 1'b0;
    r.status_val = 1'b0;
    r.raise      = 1'b0;
    r.success    = 1'b0;
    confirm      = 1'b0;
    stop         = 1'b0;
    fail         = 1'b0;
    if (phase == PH_IDLE || phase == PH_RETRY) begin
      if (!fitted || sensed) begin
        confirm = 1'b1;
      end else if (tmo == '0) begin
        // immediate check failed, retract keeps its phase
        stop = 1'b1;
        fail = 1'b1;
        if (!is_ret) begin
          r.phase = PH_IDLE;
        end
      end else begin
        r.wait_tmr = tmo;
        r.phase    = PH_WAIT;
      end
    end
    if (!stop && !confirm && r.phase == PH_WAIT) begin
      stop = 1'b1;
      if (sensed) begin
        confirm = 1'b1;
        stop    = 1'b0;
      end else if (paused) begin
        r.wait_tmr = tmo;
      end else if (r.wait_tmr == '0) begin
        fail    = 1'b1;
        r.phase = PH_IDLE;
      end
    end
    if (fail) begin
      r.status_wr  = 1'b1;
      r.status_val = is_ret;
      if (running) begin
        if (fails) begin
          r.raise = 1'b1;
          r.fails = 1'b0;
          r.phase = PH_IDLE;
        end else begin
          r.fails = 1'b1;
          r.phase = PH_RETRY;
        end
      end
    end
    if (!stop) begin
      if (confirm && settle != '0) begin
        r.settle_tmr = settle;
        r.phase      = PH_SETTLE;
      end else if (confirm || r.settle_tmr == '0) begin
        r.success    = 1'b1;
        r.phase      = PH_IDLE;
        r.fails      = 1'b0;
        r.status_wr  = 1'b1;
        r.status_val = ~is_ret;
      end
    end
    poll_side = r;
  endfunction

  logic  esense;
  logic  rsense;
  poll_t pe;
  poll_t pr;
  logic  drive;
  logic  dir;
  logic  count_req;
  logic  done;
  logic  raise;
  logic  clear;
  logic  side;

  assign esense = cfg.sensor_enables[0] & (req.extend_sensor_raw ^ cfg.polarity_bits[1]);
  assign rsense = cfg.sensor_enables[1] & (req.retract_sensor_raw ^ cfg.polarity_bits[2]);

  assign pe = poll_side(1'b0, st.ext_phase, st.ext_fail, st.ext_wait, st.ext_settle_tmr,
                        cfg.extend_timeout, cfg.extend_settle, cfg.sensor_enables[0],
                        esense, req.system_running, req.handler_paused);
  assign pr = poll_side(1'b1, st.ret_phase, st.ret_fail, st.ret_wait, st.ret_settle_tmr,
                        cfg.retract_timeout, cfg.retract_settle, cfg.sensor_enables[1],
                        rsense, req.system_running, req.handler_paused);

  always_comb begin
    st_nxt    = st;
    drive     = 1'b0;
    dir       = 1'b0;
    count_req = 1'b0;
    done      = 1'b0;
    raise     = 1'b0;
    clear     = 1'b0;
    side      = 1'b0;
    unique case (cmd_t'(req.cmd))
      CMD_POLL_EXT: begin
        drive                 = 1'b1;
        dir                   = 1'b1;
        st_nxt.ext_phase      = pe.phase;
        st_nxt.ext_fail       = pe.fails;
        st_nxt.ext_wait       = pe.wait_tmr;
        st_nxt.ext_settle_tmr = pe.settle_tmr;
        if (pe.status_wr) begin
          st_nxt.status_flag = pe.status_val;
        end
        if (pe.success) begin
          st_nxt.extended_flag = 1'b1;
        end
        count_req = pe.success;
        done      = pe.success;
        raise     = pe.raise;
        clear     = pe.success;
      end
      CMD_POLL_RET: begin
        drive                 = 1'b1;
        st_nxt.ret_phase      = pr.phase;
        st_nxt.ret_fail       = pr.fails;
        st_nxt.ret_wait       = pr.wait_tmr;
        st_nxt.ret_settle_tmr = pr.settle_tmr;
        if (pr.status_wr) begin
          st_nxt.status_flag = pr.status_val;
        end
        if (pr.success) begin
          st_nxt.extended_flag = 1'b0;
        end
        done  = pr.success;
        raise = pr.raise;
        clear = pr.success;
        side  = pr.raise | pr.success;
      end
      CMD_FORCE_ON: begin
        drive                = 1'b1;
        dir                  = 1'b1;
        st_nxt.status_flag   = 1'b1;
        st_nxt.extended_flag = 1'b1;
        st_nxt.ext_phase     = PH_IDLE;
      end
      CMD_FORCE_OFF: begin
        drive                = 1'b1;
        st_nxt.status_flag   = 1'b0;
        st_nxt.extended_flag = 1'b0;
        st_nxt.ret_phase     = PH_IDLE;
      end
      CMD_RESET: begin
        st_nxt.ext_phase = PH_IDLE;
        st_nxt.ret_phase = PH_IDLE;
        st_nxt.ext_fail  = 1'b0;
        st_nxt.ret_fail  = 1'b0;
      end
      CMD_TICK: begin
        st_nxt.ext_wait       = dec_tmr(st.ext_wait);
        st_nxt.ret_wait       = dec_tmr(st.ret_wait);
        st_nxt.ext_settle_tmr = dec_tmr(st.ext_settle_tmr);
        st_nxt.ret_settle_tmr = dec_tmr(st.ret_settle_tmr);
      end
      CMD_ABORT_EXT: begin
        st_nxt.ext_phase = PH_RETRY;
      end
      CMD_ABORT_RET: begin
        st_nxt.ret_phase = PH_RETRY;
      end
    endcase

    // valve pin, polarity bit0 marks active-low wiring
    if (drive && cfg.actuator_enable) begin
      st_nxt.valve_level = dir ? ~cfg.polarity_bits[0] : cfg.polarity_bits[0];
    end

    // direction change count, extend success counts even when disabled
    if (((drive && cfg.actuator_enable) || count_req) &&
        (st.last_dir != dir || st.first_cmd)) begin
      st_nxt.first_cmd = 1'b0;
      st_nxt.last_dir  = dir;
      if (st.trans_cnt != CNT_MAX) begin
        st_nxt.trans_cnt = st.trans_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end

    if (raise && st.tmo_cnt != CNT_MAX) begin
      st_nxt.tmo_cnt = st.tmo_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
    end

    rsp.motion_done       = done;
    rsp.valve_drive       = st_nxt.valve_level;
    rsp.position_status   = st_nxt.status_flag;
    rsp.cylinder_extended = st_nxt.extended_flag;
    rsp.motions_idle      = (st_nxt.ext_phase == PH_IDLE) && (st_nxt.ret_phase == PH_IDLE);
    rsp.alarm_raise       = raise;
    rsp.alarm_clear       = clear;
    rsp.alarm_side        = side;
    rsp.timeout_total     = st_nxt.tmo_cnt;
    rsp.transition_total  = st_nxt.trans_cnt;
  end

endmodule

### src/pneumatic_cylinder_actuator_control_unit.sv
// ----------------------------------------------------------------------------
// pneumatic_cylinder_actuator_control_unit: pneumatic cylinder controller
// Takes one command request per cycle and returns one status result per
// request: valve level, believed position, alarm pulses and counters.
// ----------------------------------------------------------------------------
// Flow: one request is taken every clock cycle while in_stall is low, and its
// result is presented from the output register. A request is captured in an
// input register, the whole command (sensor check, timers, failure and alarm
// logic, saturating counters) is resolved in one pass of the core logic, and
// the result lands in the output register while the cylinder state updates.
// A stalled result holds the output register; the input register then holds
// one more request before in_stall rises. Configuration writes take effect
// on the next cycle and should be made while no request is in flight.
module pneumatic_cylinder_actuator_control_unit import pcac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_data_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam state_t RST_STATE = '{
    ext_phase:      PH_IDLE,
    ret_phase:      PH_IDLE,
    ext_fail:       1'b0,
    ret_fail:       1'b0,
    ext_wait:       '0,
    ret_wait:       '0,
    ext_settle_tmr: '0,
    ret_settle_tmr: '0,
    status_flag:    1'b0,
    extended_flag:  1'b0,
    last_dir:       1'b0,
    first_cmd:      1'b1,
    valve_level:    1'b0,
    tmo_cnt:        '0,
    trans_cnt:      '0
  };

  cfg_t      cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      s1_valid_r;
  in_data_t  s1_data_r;
  logic      out_valid_r;
  out_data_t out_data_r;
  out_data_t rsp;
  logic      out_free;
  logic      adv;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pcac_core u_core (
    .cfg    (cfg_r),
    .st     (state_r),
    .req    (s1_data_r),
    .st_nxt (state_nxt),
    .rsp    (rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ACT_EN:     cfg_r.actuator_enable <= cfg_data[0];
        CFG_SENS_EN:    cfg_r.sensor_enables  <= cfg_data[1:0];
        CFG_POLARITY:   cfg_r.polarity_bits   <= cfg_data[2:0];
        CFG_EXT_TMO:    cfg_r.extend_timeout  <= cfg_data[TMR_W-1:0];
        CFG_RET_TMO:    cfg_r.retract_timeout <= cfg_data[TMR_W-1:0];
        CFG_EXT_SETTLE: cfg_r.extend_settle   <= cfg_data[TMR_W-1:0];
        CFG_RET_SETTLE: cfg_r.retract_settle  <= cfg_data[TMR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // cylinder state and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RST_STATE;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= rsp;
    end
  end

  // raise and clear never come from the same request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.alarm_raise && out_data_r.alarm_clear))
    else $error("alarm raise and clear in one result");

  // a completed motion always clears its alarm side
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.motion_done) |-> out_data_r.alarm_clear)
    else $error("motion done without alarm clear");

  // timeout count never goes backward
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> state_r.tmo_cnt >= $past(state_r.tmo_cnt))
    else $error("timeout count decreased");

  // a held request in the input stage is kept until it moves on
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("held request lost");

endmodule

### sim/tb_pneumatic_cylinder_actuator_control_unit.sv
// ----------------------------------------------------------------------------
// tb_pneumatic_cylinder_actuator_control_unit: cylinder controller testbench
// Sends command requests through a queue-fed driver and checks every status
// result against an in-bench prediction of the controller. The run has a
// directed part for each command and each failure, alarm and settle case.
// A random part follows under changing register settings, with idle and
// stall bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_pneumatic_cylinder_actuator_control_unit;
  import pcac_pkg::*;

  localparam logic SIDE_EXT = 1'b0;
  localparam logic SIDE_RET = 1'b1;
  localparam logic DIR_RET  = 1'b0;
  localparam logic DIR_EXT  = 1'b1;
  localparam int unsigned HOLD_AT     = 200;
  localparam int unsigned HOLD_LEN    = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 230;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_data_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_data_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_data_t    pending[$];
  out_data_t   expected_results[$];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned errors = 0;

  // predicted controller state
  cfg_t             cfg_m;
  phase_t           ext_ph, ret_ph;
  logic             ext_miss, ret_miss;
  logic [TMR_W-1:0] ext_wait_tmr, ret_wait_tmr, ext_hold_tmr, ret_hold_tmr;
  logic             believed_ext, ext_last, prev_dir, fresh, valve_pin;
  logic [CNT_W-1:0] alarm_cnt, change_cnt;
  logic             raise_p, clear_p, side_p;

  pneumatic_cylinder_actuator_control_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic coin(int unsigned pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  task automatic clear_model();
    cfg_m = '0;
    ext_ph = PH_IDLE; ret_ph = PH_IDLE;
    ext_miss = 1'b0; ret_miss = 1'b0;
    ext_wait_tmr = '0; ret_wait_tmr = '0; ext_hold_tmr = '0; ret_hold_tmr = '0;
    believed_ext = 1'b0; ext_last = 1'b0; prev_dir = 1'b0; fresh = 1'b1;
    valve_pin = 1'b0; alarm_cnt = '0; change_cnt = '0;
  endtask

  function automatic void note_direction(logic dir);
    if (prev_dir != dir || fresh) begin
      fresh = 1'b0;
      prev_dir = dir;
      change_cnt = sat_up(change_cnt);
    end
  endfunction

  function automatic void drive_valve(logic dir);
    if (cfg_m.actuator_enable) begin
      valve_pin = dir ? ~cfg_m.polarity_bits[0] : cfg_m.polarity_bits[0];
      note_direction(dir);
    end
  endfunction

  // second failure in a row raises the alarm and rearms the side
  function automatic void log_miss(logic side);
    logic   m;
    phase_t ph;
    m = (side == SIDE_RET) ? ret_miss : ext_miss;
    if (m) begin
      alarm_cnt = sat_up(alarm_cnt);
      raise_p = 1'b1;
      side_p = side;
      m = 1'b0;
      ph = PH_IDLE;
    end else begin
      m = 1'b1;
      ph = PH_RETRY;
    end
    if (side == SIDE_RET) begin
      ret_miss = m;
      ret_ph = ph;
    end else begin
      ext_miss = m;
      ext_ph = ph;
    end
  endfunction

  function automatic logic run_poll(logic side, logic sensed, logic running, logic paused);
    phase_t           ph;
    logic [TMR_W-1:0] wait_t, hold_t, limit, settle;
    logic             fitted, confirm, failed, parked, done;
    ph     = (side == SIDE_RET) ? ret_ph : ext_ph;
    wait_t = (side == SIDE_RET) ? ret_wait_tmr : ext_wait_tmr;
    hold_t = (side == SIDE_RET) ? ret_hold_tmr : ext_hold_tmr;
    limit  = (side == SIDE_RET) ? cfg_m.retract_timeout : cfg_m.extend_timeout;
    settle = (side == SIDE_RET) ? cfg_m.retract_settle : cfg_m.extend_settle;
    fitted = (side == SIDE_RET) ? cfg_m.sensor_enables[1] : cfg_m.sensor_enables[0];
    confirm = 1'b0;
    failed = 1'b0;
    parked = 1'b0;
    done = 1'b0;
    drive_valve((side == SIDE_RET) ? DIR_RET : DIR_EXT);
    if (ph == PH_IDLE || ph == PH_RETRY) begin
      if (!fitted || sensed) begin
        confirm = 1'b1;
      end else if (limit == '0) begin
        failed = 1'b1;
        // a retract that fails at once keeps its phase
        if (side == SIDE_EXT) ph = PH_IDLE;
      end else begin
        wait_t = limit;
        ph = PH_WAIT;
      end
    end
    if (!confirm && !failed && ph == PH_WAIT) begin
      if (sensed) begin
        confirm = 1'b1;
      end else if (paused) begin
        wait_t = limit;
        parked = 1'b1;
      end else if (wait_t == '0) begin
        failed = 1'b1;
        ph = PH_IDLE;
      end else begin
        parked = 1'b1;
      end
    end
    if (!failed && !parked) begin
      if (confirm && settle == '0) begin
        done = 1'b1;
      end else begin
        if (confirm) begin
          hold_t = settle;
          ph = PH_SETTLE;
        end
        done = (hold_t == '0);
      end
    end
    if (side == SIDE_RET) begin
      ret_ph = ph; ret_wait_tmr = wait_t; ret_hold_tmr = hold_t;
    end else begin
      ext_ph = ph; ext_wait_tmr = wait_t; ext_hold_tmr = hold_t;
    end
    if (failed) begin
      believed_ext = (side == SIDE_RET);
      if (running) log_miss(side);
    end
    if (done) begin
      clear_p = 1'b1;
      side_p = side;
      believed_ext = (side == SIDE_EXT);
      ext_last = (side == SIDE_EXT);
      if (side == SIDE_EXT) begin
        ext_ph = PH_IDLE;
        ext_miss = 1'b0;
        note_direction(DIR_EXT);
      end else begin
        ret_ph = PH_IDLE;
        ret_miss = 1'b0;
      end
    end
    return done;
  endfunction

  function automatic out_data_t cylinder_step(in_data_t rq);
    out_data_t r;
    logic      ext_seen, ret_seen, done;
    ext_seen = cfg_m.sensor_enables[0] & (rq.extend_sensor_raw ^ cfg_m.polarity_bits[1]);
    ret_seen = cfg_m.sensor_enables[1] & (rq.retract_sensor_raw ^ cfg_m.polarity_bits[2]);
    raise_p = 1'b0;
    clear_p = 1'b0;
    side_p = SIDE_EXT;
    done = 1'b0;
    case (rq.cmd)
      CMD_POLL_EXT: done = run_poll(SIDE_EXT, ext_seen, rq.system_running, rq.handler_paused);
      CMD_POLL_RET: done = run_poll(SIDE_RET, ret_seen, rq.system_running, rq.handler_paused);
      CMD_FORCE_ON: begin
        believed_ext = 1'b1;
        ext_last = 1'b1;
        ext_ph = PH_IDLE;
        drive_valve(DIR_EXT);
      end
      CMD_FORCE_OFF: begin
        believed_ext = 1'b0;
        ext_last = 1'b0;
        ret_ph = PH_IDLE;
        drive_valve(DIR_RET);
      end
      CMD_RESET: begin
        ext_ph = PH_IDLE;
        ret_ph = PH_IDLE;
        ext_miss = 1'b0;
        ret_miss = 1'b0;
      end
      CMD_TICK: begin
        if (ext_wait_tmr != '0) ext_wait_tmr = ext_wait_tmr - 1'b1;
        if (ret_wait_tmr != '0) ret_wait_tmr = ret_wait_tmr - 1'b1;
        if (ext_hold_tmr != '0) ext_hold_tmr = ext_hold_tmr - 1'b1;
        if (ret_hold_tmr != '0) ret_hold_tmr = ret_hold_tmr - 1'b1;
      end
      CMD_ABORT_EXT: ext_ph = PH_RETRY;
      default: ret_ph = PH_RETRY;
    endcase
    r.motion_done       = done;
    r.valve_drive       = valve_pin;
    r.position_status   = believed_ext;
    r.cylinder_extended = ext_last;
    r.motions_idle      = (ext_ph == PH_IDLE) && (ret_ph == PH_IDLE);
    r.alarm_raise       = raise_p;
    r.alarm_clear       = clear_p;
    r.alarm_side        = side_p;
    r.timeout_total     = alarm_cnt;
    r.transition_total  = change_cnt;
    return r;
  endfunction

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("result %0d %s: expected %0h got %0h", n_results, fname, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(cylinder_step(in_data));
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending.pop_front();
        if (coin(gap_pct)) gap_left <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long output hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    out_data_t want;
    logic      burst;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: %0h", n_results, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("motion_done", 16'(want.motion_done), 16'(out_data.motion_done));
          check_field("valve_drive", 16'(want.valve_drive), 16'(out_data.valve_drive));
          check_field("position_status", 16'(want.position_status),
                      16'(out_data.position_status));
          check_field("cylinder_extended", 16'(want.cylinder_extended),
                      16'(out_data.cylinder_extended));
          check_field("motions_idle", 16'(want.motions_idle), 16'(out_data.motions_idle));
          check_field("alarm_raise", 16'(want.alarm_raise), 16'(out_data.alarm_raise));
          check_field("alarm_clear", 16'(want.alarm_clear), 16'(out_data.alarm_clear));
          check_field("alarm_side", 16'(want.alarm_side), 16'(out_data.alarm_side));
          check_field("timeout_total", want.timeout_total, out_data.timeout_total);
          check_field("transition_total", want.transition_total, out_data.transition_total);
        end
        n_results++;
      end
      burst = 1'b0;
      if (stall_left != 0) begin
        burst = 1'b1;
        stall_left <= stall_left - 1;
      end else if (coin(stall_pct)) begin
        burst = 1'b1;
        stall_left <= $urandom_range(0, 8);
      end
      out_stall <= burst || (hold_left != 0);
    end
  end

  function automatic in_data_t req(cmd_t c, logic er, logic rr, logic run, logic pau);
    in_data_t r;
    r.cmd = c;
    r.extend_sensor_raw = er;
    r.retract_sensor_raw = rr;
    r.system_running = run;
    r.handler_paused = pau;
    return r;
  endfunction

  // polls of one side with random sensors, ticks in between
  function automatic void add_motion();
    cmd_t pc;
    logic run;
    pc = coin(50) ? CMD_POLL_RET : CMD_POLL_EXT;
    run = coin(80);
    repeat ($urandom_range(1, 8)) begin
      pending.push_back(req(pc, coin(50), coin(50), run, coin(15)));
      repeat ($urandom_range(0, 3))
        pending.push_back(req(CMD_TICK, coin(50), coin(50), coin(50), coin(50)));
    end
  endfunction

  function automatic logic [TMR_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return TMR_W'($urandom);
      1: return '1;
      default: return TMR_W'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    c.actuator_enable = coin(80);
    c.sensor_enables = 2'($urandom);
    c.polarity_bits = 3'($urandom);
    c.extend_timeout = pick_ticks();
    c.retract_timeout = pick_ticks();
    c.extend_settle = pick_ticks();
    c.retract_settle = pick_ticks();
    return c;
  endfunction

  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ACT_EN:     cfg_m.actuator_enable = val[0];
      CFG_SENS_EN:    cfg_m.sensor_enables = val[1:0];
      CFG_POLARITY:   cfg_m.polarity_bits = val[2:0];
      CFG_EXT_TMO:    cfg_m.extend_timeout = val;
      CFG_RET_TMO:    cfg_m.retract_timeout = val;
      CFG_EXT_SETTLE: cfg_m.extend_settle = val;
      default:        cfg_m.retract_settle = val;
    endcase
  endtask

  // unused upper bits of the narrow registers carry junk
  task automatic load_setup(cfg_t c);
    set_reg(CFG_ACT_EN, {15'($urandom), c.actuator_enable});
    set_reg(CFG_SENS_EN, {14'($urandom), c.sensor_enables});
    set_reg(CFG_POLARITY, {13'($urandom), c.polarity_bits});
    set_reg(CFG_EXT_TMO, c.extend_timeout);
    set_reg(CFG_RET_TMO, c.retract_timeout);
    set_reg(CFG_EXT_SETTLE, c.extend_settle);
    set_reg(CFG_RET_SETTLE, c.retract_settle);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    cfg_t        setup;
    logic [31:0] noise;
    int unsigned p;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 20;
    stall_pct = 20;

    // reset settings: valve disabled, no sensors fitted
    pending.push_back(req(CMD_POLL_EXT, 1'b0, 1'b0, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b1, 1'b1, 1'b0, 1'b1));
    pending.push_back(req(CMD_FORCE_ON, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_FORCE_OFF, 1'b1, 1'b1, 1'b1, 1'b1));
    pending.push_back(req(CMD_ABORT_EXT, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_ABORT_RET, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_RESET, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_idle();

    // immediate checks: misses, alarms and clears on both sides
    setup = '0;
    setup.actuator_enable = 1'b1;
    setup.sensor_enables = 2'b11;
    load_setup(setup);
    pending.push_back(req(CMD_POLL_EXT, 1'b0, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b0, 1'b0, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b1, 1'b0, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b0, 1'b0, 1'b0, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b0, 1'b0, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b0, 1'b0, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b0, 1'b1, 1'b1, 1'b1));
    wait_idle();

    // active-low wiring, timed wait with pause, expiry and settle
    setup.polarity_bits = 3'b111;
    setup.extend_timeout = 16'd2;
    setup.retract_timeout = 16'd1;
    setup.extend_settle = 16'd1;
    load_setup(setup);
    pending.push_back(req(CMD_POLL_EXT, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b1, 1'b1, 1'b1, 1'b1));
    pending.push_back(req(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b0, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_EXT, 1'b1, 1'b1, 1'b1, 1'b0));
    pending.push_back(req(CMD_POLL_RET, 1'b1, 1'b0, 1'b1, 1'b0));
    wait_idle();

    for (p = 0; p < 7; p++) begin
      if (p == 0) setup = '1;
      else if (p == 1) setup = '0;
      else setup = random_setup();
      load_setup(setup);
      gap_pct = (p == 6) ? 0 : 10 * $urandom_range(0, 3);
      stall_pct = (p == 6) ? 0 : 10 * $urandom_range(0, 3);
      while (pending.size() < PHASE_ITEMS) begin
        if (coin(70)) begin
          add_motion();
        end else begin
          noise = $urandom;
          pending.push_back(in_data_t'(noise[6:0]));
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
